// ===== sv/rpd_pkg.sv =====
`default_nettype none
package rpd_pkg;

	localparam int unsigned BYTE_W   = 8;
	localparam int unsigned OFFSET_W = 17;
	localparam int unsigned LEN_W    = 16;
	localparam int unsigned TICK_W   = 16;

	// Frame markers and codes
	localparam logic [BYTE_W-1:0] START_BYTE     = 8'hEF;
	localparam logic [BYTE_W-1:0] SECOND_BYTE    = 8'h01;
	localparam logic [BYTE_W-1:0] ACK_ID         = 8'h07;
	localparam logic [BYTE_W-1:0] TIMEOUT_STATUS = 8'hFF;

	// Fixed header positions
	localparam logic [OFFSET_W-1:0] POS_HUNT    = 17'd0;
	localparam logic [OFFSET_W-1:0] POS_SECOND  = 17'd1;
	localparam logic [OFFSET_W-1:0] POS_IDENT   = 17'd6;
	localparam logic [OFFSET_W-1:0] POS_LEN_HI  = 17'd7;
	localparam logic [OFFSET_W-1:0] POS_LEN_LO  = 17'd8;
	localparam logic [OFFSET_W-1:0] HEADER_LEN  = 17'd9;

	localparam logic [TICK_W-1:0] TIMEOUT_RESET = 16'd3000;

	typedef enum logic {
		KIND_BYTE = 1'b0,
		KIND_TICK = 1'b1
	} item_kind_t;

endpackage
`default_nettype wire

// ===== sv/rpd_in_if.sv =====
`default_nettype none
interface rpd_in_if;
	logic                         valid;
	logic                         ready;
	logic                         kind;
	logic [rpd_pkg::BYTE_W-1:0]   byte_value;

	modport source (output valid, output kind, output byte_value, input ready);
	modport sink   (input valid, input kind, input byte_value, output ready);
endinterface
`default_nettype wire

// ===== sv/rpd_out_if.sv =====
`default_nettype none
interface rpd_out_if;
	logic                           valid;
	logic                           ready;
	logic [rpd_pkg::BYTE_W-1:0]     byte_out;
	logic [rpd_pkg::OFFSET_W-1:0]   offset;
	logic                           packet_done;
	logic [rpd_pkg::BYTE_W-1:0]     packet_id;
	logic                           timed_out;
	logic [rpd_pkg::BYTE_W-1:0]     status_code;

	modport source (output valid, output byte_out, output offset, output packet_done,
		output packet_id, output timed_out, output status_code, input ready);
	modport sink   (input valid, input byte_out, input offset, input packet_done,
		input packet_id, input timed_out, input status_code, output ready);
endinterface
`default_nettype wire

// ===== sv/response_packet_deframer.sv =====
// Response packet deframer.
// in_ch carries one item per received UART byte (kind 0, byte_value) or per
// time tick (kind 1). out_ch carries one result per kept packet byte, with its
// offset from the 0xEF start byte, the packet identifier and the latched
// acknowledge status; packet_done marks the last byte of a packet. A tick that
// brings the tick count up to timeout_ticks aborts any packet and gives a
// result with timed_out set and status 0xFF.
// A result passes through the input register and then the output register
// to out_ch. One item per cycle while out_ch is not stalled; the state update
// for an item is done in the single stage between the two registers.
// cfg_wr_en/cfg_wr_data write timeout_ticks; write it only while idle.
// Reset clears the framer to hunting, the tick count, identifier and status
// to zero, and timeout_ticks to 3000. Both registers are emptied.
// When the receiver stalls, the output register holds its result and the
// input register still takes one more item; then in_ch.ready drops until
// out_ch.ready returns. Items that give no result never wait on out_ch.
`default_nettype none
module response_packet_deframer (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	rpd_in_if.sink                             in_ch,
	rpd_out_if.source                          out_ch,
	input  wire logic                          cfg_wr_en,
	input  wire logic [rpd_pkg::TICK_W-1:0]    cfg_wr_data
);

	// input register
	logic                          valid_s1;
	logic                          kind_s1;
	logic [rpd_pkg::BYTE_W-1:0]    byte_s1;

	// framer state
	logic [rpd_pkg::OFFSET_W-1:0]  pos_q;
	logic [rpd_pkg::LEN_W-1:0]     len_q;
	logic [rpd_pkg::BYTE_W-1:0]    ident_q;
	logic [rpd_pkg::BYTE_W-1:0]    status_q;
	logic [rpd_pkg::BYTE_W-1:0]    capture_q;
	logic [rpd_pkg::TICK_W-1:0]    tick_q;
	logic [rpd_pkg::TICK_W-1:0]    timeout_q;

	// output register
	logic                          out_valid_q;
	logic [rpd_pkg::BYTE_W-1:0]    out_byte_q;
	logic [rpd_pkg::OFFSET_W-1:0]  out_offset_q;
	logic                          out_done_q;
	logic [rpd_pkg::BYTE_W-1:0]    out_id_q;
	logic                          out_tmo_q;
	logic [rpd_pkg::BYTE_W-1:0]    out_status_q;

	// next-state logic
	logic                          is_tick;
	logic [rpd_pkg::OFFSET_W-1:0]  tick_next;
	logic                          tmo_hit;
	logic                          keep_byte;
	logic                          second_bad;
	logic [rpd_pkg::BYTE_W-1:0]    ident_n;
	logic [rpd_pkg::LEN_W-1:0]     len_n;
	logic [rpd_pkg::BYTE_W-1:0]    capture_n;
	logic [rpd_pkg::OFFSET_W-1:0]  pos_inc;
	logic [rpd_pkg::OFFSET_W-1:0]  total;
	logic                          pkt_done;
	logic                          has_result;
	logic                          advance;
	logic                          out_load;

	// decode the item in the input register against the framer state
	always_comb begin
		is_tick    = (kind_s1 == rpd_pkg::KIND_TICK);
		tick_next  = {1'b0, tick_q} + 17'd1;
		tmo_hit    = (tick_next >= {1'b0, timeout_q});
		second_bad = (pos_q == rpd_pkg::POS_SECOND) && (byte_s1 != rpd_pkg::SECOND_BYTE);
		keep_byte  = !is_tick
			&& !((pos_q == rpd_pkg::POS_HUNT) && (byte_s1 != rpd_pkg::START_BYTE))
			&& !second_bad;

		ident_n   = (pos_q == rpd_pkg::POS_IDENT) ? byte_s1 : ident_q;
		len_n     = len_q;
		if (pos_q == rpd_pkg::POS_LEN_HI) begin
			len_n = {byte_s1, len_q[7:0]};
		end else if (pos_q == rpd_pkg::POS_LEN_LO) begin
			len_n = {len_q[15:8], byte_s1};
		end
		capture_n = (pos_q == rpd_pkg::HEADER_LEN) ? byte_s1 : capture_q;

		pos_inc  = pos_q + 17'd1;
		total    = {1'b0, len_n} + rpd_pkg::HEADER_LEN;
		pkt_done = (pos_q >= rpd_pkg::POS_LEN_LO) && (pos_inc >= total);

		has_result = valid_s1 && (is_tick ? tmo_hit : keep_byte);
		advance    = valid_s1 && (!has_result || !out_valid_q || out_ch.ready);
		out_load   = advance && has_result;
	end

	assign in_ch.ready = !valid_s1 || advance;

	// take an item whenever the input register is free or moving on
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ch.ready) begin
			valid_s1 <= in_ch.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ch.ready && in_ch.valid) begin
			kind_s1 <= in_ch.kind;
			byte_s1 <= in_ch.byte_value;
		end
	end

	// hold timeout register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timeout_q <= rpd_pkg::TIMEOUT_RESET;
		end else if (cfg_wr_en) begin
			timeout_q <= cfg_wr_data;
		end
	end

	// advance framer state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q     <= rpd_pkg::POS_HUNT;
			len_q     <= '0;
			ident_q   <= '0;
			status_q  <= '0;
			capture_q <= '0;
			tick_q    <= '0;
		end else if (advance) begin
			if (is_tick) begin
				if (tmo_hit) begin
					pos_q    <= rpd_pkg::POS_HUNT;
					tick_q   <= '0;
					status_q <= rpd_pkg::TIMEOUT_STATUS;
				end else begin
					tick_q   <= tick_next[rpd_pkg::TICK_W-1:0];
				end
			end else if (second_bad) begin
				pos_q <= rpd_pkg::POS_HUNT;
			end else if (keep_byte) begin
				ident_q   <= ident_n;
				len_q     <= len_n;
				capture_q <= capture_n;
				if (pkt_done) begin
					pos_q  <= rpd_pkg::POS_HUNT;
					tick_q <= '0;
					if ((ident_n == rpd_pkg::ACK_ID) && (len_n != '0)) begin
						status_q <= capture_n;
					end
				end else begin
					pos_q <= pos_inc;
				end
			end
		end
	end

	// output register: load a result, drop it once taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ch.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_tmo_q <= is_tick;
			if (is_tick) begin
				out_byte_q   <= '0;
				out_offset_q <= '0;
				out_done_q   <= 1'b0;
				out_id_q     <= ident_q;
				out_status_q <= rpd_pkg::TIMEOUT_STATUS;
			end else begin
				out_byte_q   <= byte_s1;
				out_offset_q <= pos_q;
				out_done_q   <= pkt_done;
				out_id_q     <= ident_n;
				out_status_q <= (pkt_done && (ident_n == rpd_pkg::ACK_ID) && (len_n != '0))
					? capture_n : status_q;
			end
		end
	end

	assign out_ch.valid       = out_valid_q;
	assign out_ch.byte_out    = out_byte_q;
	assign out_ch.offset      = out_offset_q;
	assign out_ch.packet_done = out_done_q;
	assign out_ch.packet_id   = out_id_q;
	assign out_ch.timed_out   = out_tmo_q;
	assign out_ch.status_code = out_status_q;

endmodule
`default_nettype wire

// ===== sv/rpd_checker.sv =====
`default_nettype none
module rpd_checker (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            out_valid,
	input  wire logic                            out_ready,
	input  wire logic [rpd_pkg::BYTE_W-1:0]      byte_out,
	input  wire logic [rpd_pkg::OFFSET_W-1:0]    offset,
	input  wire logic                            packet_done,
	input  wire logic                            timed_out,
	input  wire logic [rpd_pkg::BYTE_W-1:0]      status_code
);

	// a stalled result holds its payload
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(byte_out) && $stable(offset)
			&& $stable(packet_done) && $stable(timed_out) && $stable(status_code))
		else $error("stalled result changed");

	// a timeout result carries no byte and the timeout status
	a_tmo: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && timed_out |-> byte_out == '0 && offset == '0 && !packet_done
			&& status_code == rpd_pkg::TIMEOUT_STATUS)
		else $error("malformed timeout result");

	// a packet never ends before the length low byte of its header
	a_done: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && packet_done |-> offset >= rpd_pkg::POS_LEN_LO && !timed_out)
		else $error("packet ended inside header");

	// the first two kept bytes are the frame markers
	a_mark: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !timed_out && (offset == rpd_pkg::POS_HUNT || offset == rpd_pkg::POS_SECOND)
			|-> (offset == rpd_pkg::POS_HUNT && byte_out == rpd_pkg::START_BYTE)
			|| (offset == rpd_pkg::POS_SECOND && byte_out == rpd_pkg::SECOND_BYTE))
		else $error("frame marker mismatch");

endmodule

bind response_packet_deframer rpd_checker u_rpd_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.out_valid   (out_ch.valid),
	.out_ready   (out_ch.ready),
	.byte_out    (out_ch.byte_out),
	.offset      (out_ch.offset),
	.packet_done (out_ch.packet_done),
	.timed_out   (out_ch.timed_out),
	.status_code (out_ch.status_code)
);
`default_nettype wire
